/* rtl/core/sbm_pkg.sv */
// ----------------------------------------------------------------------------
// Sparse block memory package
// Shared widths, codes and the control structs between the sequencer and the
// block lookup unit.
// ----------------------------------------------------------------------------
package sbm_pkg;

   localparam int BYTE_W = 8;
   localparam int DATA_W = 64;
   localparam int ADDR_W = 64;
   localparam int SIZE_W = 4;
   localparam int LANES = DATA_W / BYTE_W;
   localparam int LANE_W = $clog2(LANES);

   localparam logic [SIZE_W-1:0] MAX_BYTES = SIZE_W'(LANES);

   localparam logic MODE_READ = 1'b0;
   localparam logic MODE_WRITE = 1'b1;

   typedef struct packed {
      logic start;
      logic alloc;
   } sbm_look_req_type;

   typedef struct packed {
      logic done;
      logic found;
   } sbm_look_rsp_type;

endpackage

/* rtl/core/sbm_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sbm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/sbm_lookup.sv */
// ----------------------------------------------------------------------------
// Block lookup unit
// Scans the allocated block tags one per cycle through a single comparator
// and allocates the next free block on a write miss.
// ----------------------------------------------------------------------------
module sbm_lookup #(
   parameter int BLOCK_COUNT = 16,
   parameter int BLOCK_SHIFT = 12,
   parameter int IDX_W = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  sbm_pkg::sbm_look_req_type        look_req,
   input  logic [sbm_pkg::ADDR_W-BLOCK_SHIFT-1:0] base,
   output sbm_pkg::sbm_look_rsp_type        look_rsp,
   output logic [IDX_W-1:0]                 blk_idx
);
   import sbm_pkg::*;

   localparam int TAG_W = ADDR_W - BLOCK_SHIFT;
   localparam int CNT_W = $clog2(BLOCK_COUNT + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic             busy_ff, busy_in;
   logic             cmp_ff, cmp_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic             alloc_ff, alloc_in;
   logic [TAG_W-1:0] base_ff, base_in;
   sbm_look_rsp_type rsp_ff, rsp_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   logic             tag_we;
   logic             tag_re;
   logic [TAG_W-1:0] tag_rdata;
   logic             match;

   sbm_ram #(
      .WIDTH(TAG_W),
      .DEPTH(BLOCK_COUNT),
      .AW   (IDX_W)
   ) u_tag_ram (
      .clock  (clock),
      .wr_en  (tag_we),
      .wr_addr(count_ff[IDX_W-1:0]),
      .wr_data(base_ff),
      .rd_en  (tag_re),
      .rd_addr(scan_ff[IDX_W-1:0]),
      .rd_data(tag_rdata)
   );

   assign match = cmp_ff && (tag_rdata == base_ff);

   always_comb begin
      count_in = count_ff;
      scan_in = scan_ff;
      busy_in = busy_ff;
      cmp_in = cmp_ff;
      cmp_idx_in = cmp_idx_ff;
      alloc_in = alloc_ff;
      base_in = base_ff;
      rsp_in = '0;
      idx_in = idx_ff;
      tag_we = 1'b0;
      tag_re = 1'b0;
      if (!busy_ff) begin
         if (look_req.start) begin
            busy_in = 1'b1;
            scan_in = '0;
            cmp_in = 1'b0;
            alloc_in = look_req.alloc;
            base_in = base;
         end
      end else begin
         priority if (match) begin
            busy_in = 1'b0;
            rsp_in.done = 1'b1;
            rsp_in.found = 1'b1;
            idx_in = cmp_idx_ff;
         end else if (scan_ff != count_ff) begin
            tag_re = 1'b1;
            cmp_in = 1'b1;
            cmp_idx_in = scan_ff[IDX_W-1:0];
            scan_in = scan_ff + CNT_W'(1);
         end else begin
            busy_in = 1'b0;
            rsp_in.done = 1'b1;
            if (alloc_ff && (count_ff != CNT_W'(BLOCK_COUNT))) begin
               tag_we = 1'b1;
               rsp_in.found = 1'b1;
               idx_in = count_ff[IDX_W-1:0];
               count_in = count_ff + CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         busy_ff <= 1'b0;
         rsp_ff <= '0;
      end else begin
         count_ff <= count_in;
         busy_ff <= busy_in;
         rsp_ff <= rsp_in;
      end
      scan_ff <= scan_in;
      cmp_ff <= cmp_in;
      cmp_idx_ff <= cmp_idx_in;
      alloc_ff <= alloc_in;
      base_ff <= base_in;
      idx_ff <= idx_in;
   end

   assign look_rsp = rsp_ff;
   assign blk_idx = idx_ff;

endmodule

/* rtl/core/sparse_block_memory.sv */
// ----------------------------------------------------------------------------
// Sparse block memory
// A byte memory built from BLOCK_COUNT tagged blocks of 2^BLOCK_SHIFT bytes.
//
// Each req word carries a read or write of 0 to 8 bytes at a 64-bit address.
// The block whose tag matches the upper address bits is found by a scan of
// the allocated tags, one tag per cycle through one comparator. A write miss
// takes the next free block. Bytes then move one per cycle through the
// byte-wide store, little-endian, stopping at the block end. Every req word
// gives one rsp word with the read data and the number of bytes moved.
//
// The rsp word is loaded after the tag scan (up to the allocated block count
// of tags), the byte moves and the finish state; a read also waits for its
// last byte from the registered store, and a lookup that finds no block skips
// the byte moves. req_tready rises as the rsp word is loaded, so the next req
// word can be taken while it is shown. After reset the byte store is cleared
// one byte a cycle through the whole store; no req word is taken meanwhile.
// The rsp word sits in an output register; a new req word is taken while it
// waits, and the next result holds until rsp_tready frees it.
// ----------------------------------------------------------------------------
module sparse_block_memory #(
   parameter int BLOCK_COUNT = 16,
   parameter int BLOCK_SHIFT = 12
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [63:0] address, [67:64] byte_size, [131:68] write_data, [135:132] zero
   input  logic [135:0] req_tdata,
   // [0] mode
   input  logic [0:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [63:0] read_data, [67:64] bytes_done, [71:68] zero
   output logic [71:0]  rsp_tdata
);
   import sbm_pkg::*;

   localparam int IDX_W = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
   localparam int STORE_DEPTH = BLOCK_COUNT * (2 ** BLOCK_SHIFT);
   localparam int SA_W = $clog2(STORE_DEPTH);
   localparam logic [BLOCK_SHIFT:0] BLK_BYTES = (BLOCK_SHIFT + 1)'(1) << BLOCK_SHIFT;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK,
      ST_XFER,
      ST_FINISH
   } state_type;

   state_type              state_ff, state_in;
   logic [SA_W-1:0]        clr_ff, clr_in;
   logic                   mode_ff, mode_in;
   logic [BLOCK_SHIFT-1:0] off_ff, off_in;
   logic [SIZE_W-1:0]      n_ff, n_in;
   logic [SIZE_W-1:0]      j_ff, j_in;
   logic [DATA_W-1:0]      wdata_ff, wdata_in;
   logic [DATA_W-1:0]      rdata_ff, rdata_in;
   logic                   found_ff, found_in;
   logic                   rd_pend_ff, rd_pend_in;
   logic [LANE_W-1:0]      rd_lane_ff, rd_lane_in;
   logic [IDX_W-1:0]       blk_ff, blk_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]      rsp_rdata_ff, rsp_rdata_in;
   logic [SIZE_W-1:0]      rsp_done_ff, rsp_done_in;

   logic                   accept;
   logic [ADDR_W-1:0]      req_address;
   logic [SIZE_W-1:0]      req_size;
   logic [SIZE_W-1:0]      size_sat;
   logic [BLOCK_SHIFT:0]   room;
   sbm_look_req_type       look_req;
   sbm_look_rsp_type       look_rsp;
   logic [IDX_W-1:0]       look_idx;

   logic [IDX_W+BLOCK_SHIFT-1:0] st_full;
   logic [SA_W-1:0]        st_addr;
   logic                   st_we;
   logic [SA_W-1:0]        st_waddr;
   logic [BYTE_W-1:0]      st_wdata;
   logic                   st_re;
   logic [BYTE_W-1:0]      st_rdata;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept = req_tvalid && req_tready;
   assign req_address = req_tdata[ADDR_W-1:0];
   assign req_size = req_tdata[ADDR_W+SIZE_W-1:ADDR_W];
   assign size_sat = (req_size > MAX_BYTES) ? MAX_BYTES : req_size;
   assign room = BLK_BYTES - {1'b0, req_address[BLOCK_SHIFT-1:0]};

   assign look_req.start = accept;
   assign look_req.alloc = (req_tuser[0] == MODE_WRITE);

   sbm_lookup #(
      .BLOCK_COUNT(BLOCK_COUNT),
      .BLOCK_SHIFT(BLOCK_SHIFT),
      .IDX_W      (IDX_W)
   ) u_lookup (
      .clock   (clock),
      .reset   (reset),
      .look_req(look_req),
      .base    (req_address[ADDR_W-1:BLOCK_SHIFT]),
      .look_rsp(look_rsp),
      .blk_idx (look_idx)
   );

   assign st_full = {blk_ff, off_ff + BLOCK_SHIFT'(j_ff)};
   assign st_addr = st_full[SA_W-1:0];

   sbm_ram #(
      .WIDTH(BYTE_W),
      .DEPTH(STORE_DEPTH),
      .AW   (SA_W)
   ) u_store (
      .clock  (clock),
      .wr_en  (st_we),
      .wr_addr(st_waddr),
      .wr_data(st_wdata),
      .rd_en  (st_re),
      .rd_addr(st_addr),
      .rd_data(st_rdata)
   );

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      mode_in = mode_ff;
      off_in = off_ff;
      n_in = n_ff;
      j_in = j_ff;
      wdata_in = wdata_ff;
      rdata_in = rdata_ff;
      found_in = found_ff;
      rd_pend_in = 1'b0;
      rd_lane_in = j_ff[LANE_W-1:0];
      blk_in = blk_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_rdata_in = rsp_rdata_ff;
      rsp_done_in = rsp_done_ff;
      st_we = 1'b0;
      st_waddr = st_addr;
      st_wdata = wdata_ff[BYTE_W-1:0];
      st_re = 1'b0;

      for (int k = 0; k < LANES; k++) begin
         if (rd_pend_ff && (rd_lane_ff == LANE_W'(k))) begin
            rdata_in[k*BYTE_W +: BYTE_W] = st_rdata;
         end
      end

      unique case (state_ff)
         ST_CLEAR: begin
            st_we = 1'b1;
            st_waddr = clr_ff;
            st_wdata = '0;
            clr_in = clr_ff + SA_W'(1);
            if (clr_ff == SA_W'(STORE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               mode_in = req_tuser[0];
               off_in = req_address[BLOCK_SHIFT-1:0];
               n_in = ((BLOCK_SHIFT + 1)'(size_sat) < room) ? size_sat : room[SIZE_W-1:0];
               wdata_in = req_tdata[ADDR_W+SIZE_W+DATA_W-1:ADDR_W+SIZE_W];
               rdata_in = '0;
               j_in = '0;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (look_rsp.done) begin
               found_in = look_rsp.found;
               blk_in = look_idx;
               state_in = look_rsp.found ? ST_XFER : ST_FINISH;
            end
         end
         ST_XFER: begin
            if (j_ff != n_ff) begin
               j_in = j_ff + SIZE_W'(1);
               if (mode_ff == MODE_WRITE) begin
                  st_we = 1'b1;
                  wdata_in = wdata_ff >> BYTE_W;
               end else begin
                  st_re = 1'b1;
                  rd_pend_in = 1'b1;
               end
            end else if (!rd_pend_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_rdata_in = rdata_ff;
               rsp_done_in = found_ff ? n_ff : '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         rd_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rd_pend_ff <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff <= mode_in;
      off_ff <= off_in;
      n_ff <= n_in;
      j_ff <= j_in;
      wdata_ff <= wdata_in;
      rdata_ff <= rdata_in;
      found_ff <= found_in;
      rd_lane_ff <= rd_lane_in;
      blk_ff <= blk_in;
      rsp_rdata_ff <= rsp_rdata_in;
      rsp_done_ff <= rsp_done_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {4'b0000, rsp_done_ff, rsp_rdata_ff};

   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("req taken twice in a row");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_valid_ff)
      else $error("rsp word during store clear");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_XFER) |-> ((j_ff <= n_ff) && (n_ff <= MAX_BYTES)))
      else $error("byte transfer ran past its count");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (mode_ff == MODE_WRITE) && (state_ff == ST_IDLE) &&
       $past(state_ff == ST_FINISH)) |-> (rsp_rdata_ff == '0))
      else $error("write result carries read data");

endmodule
